// ===== rtl/core/tccw_pkg.sv =====
// Shared types and constants for the text console character writer.
// Holds the request and response word layouts, command codes and character codes.
// No dependencies.
package tccw_pkg;

    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 8;

    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [7:0]       char_code;
        logic [3:0]       bg_color;
        logic [3:0]       fg_color;
        logic [LOC_W-1:0] cell_address;
    } req_word_t;

    typedef struct packed {
        logic [LOC_W-1:0]  cursor_location;
        logic [CELL_W-1:0] read_data;
    } rsp_word_t;

endpackage

// ===== rtl/core/text_console_char_writer.sv =====
// Text console character writer: cell store, cursor, put, clear, read and scroll.
// A put passes from the execute state to the response state; a read adds a wait state for the registered store read.
// Scroll copies each row up by one and then blanks the last row; the store has separate read and write ports.
// Clear and the pass after reset write COLUMNS*ROWS blank cells, one per cycle; req_ready is low.
// Depends on tccw_pkg.
module text_console_char_writer #(
    parameter int COLUMNS   = tccw_pkg::DEF_COLUMNS,
    parameter int ROWS      = tccw_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tccw_pkg::DEF_TAB_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  tccw_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tccw_pkg::rsp_word_t rsp
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
    localparam int LW        = $clog2(CELLS);
    localparam int CNTW      = $clog2(CELLS + 1);
    localparam int CW        = $clog2(COLUMNS);
    localparam int NCW       = $clog2(COLUMNS + TAB_WIDTH);
    localparam int PW        = $clog2(TAB_WIDTH);
    localparam int TDW       = $clog2(TAB_WIDTH + 1);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCROLL,
        S_RESP
    } state_t;

    logic [tccw_pkg::CELL_W-1:0] mem [CELLS];
    logic [tccw_pkg::CELL_W-1:0] rd_data_reg;

    state_t                      state_reg, state_next;
    tccw_pkg::req_word_t         item_reg, item_next;
    logic [LW-1:0]               loc_reg, loc_next;
    logic [CW-1:0]               col_reg, col_next;
    logic [PW-1:0]               phase_reg, phase_next;
    logic [CNTW-1:0]             cnt_reg, cnt_next;
    logic [LW-1:0]               dst_reg, dst_next;
    logic                        pend_reg, pend_next;
    logic                        sweep_resp_reg, sweep_resp_next;
    logic                        rd_ok_reg, rd_ok_next;
    logic [tccw_pkg::CELL_W-1:0] data_reg, data_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    tccw_pkg::rsp_word_t         rsp_reg, rsp_next;

    logic                        we;
    logic [LW-1:0]               wr_addr;
    logic [tccw_pkg::CELL_W-1:0] wr_data;
    logic                        re;
    logic [LW-1:0]               rd_addr;

    logic                        last_row;
    logic [LW-1:0]               line_base;
    logic [LW-1:0]               nl_loc;
    logic [TDW-1:0]              tab_delta;
    logic [NCW-1:0]              tab_col;
    logic [PW-1:0]               phase_inc;
    logic [PW-1:0]               phase_dec;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign last_row  = (loc_reg >= LW'(LAST_BASE));
    assign line_base = loc_reg - LW'(col_reg);
    assign nl_loc    = last_row ? line_base : line_base + LW'(COLUMNS);
    assign tab_delta = TDW'(TAB_WIDTH) - TDW'(phase_reg);
    assign tab_col   = NCW'(col_reg) + NCW'(tab_delta);
    assign phase_inc = (phase_reg == PW'(TAB_WIDTH - 1)) ? '0 : phase_reg + PW'(1);
    assign phase_dec = (phase_reg == '0) ? PW'(TAB_WIDTH - 1) : phase_reg - PW'(1);

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        loc_next        = loc_reg;
        col_next        = col_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        dst_next        = dst_reg;
        pend_next       = pend_reg;
        sweep_resp_next = sweep_resp_reg;
        rd_ok_next      = rd_ok_reg;
        data_next       = data_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        we              = 1'b0;
        wr_addr         = loc_reg;
        wr_data         = tccw_pkg::BLANK_CELL;
        re              = 1'b0;
        rd_addr         = loc_reg;

        unique case (state_reg)
            S_SWEEP:
            begin
                we      = 1'b1;
                wr_addr = LW'(cnt_reg);
                wr_data = tccw_pkg::BLANK_CELL;
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(CELLS - 1))
                begin
                    state_next = sweep_resp_reg ? S_RESP : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                data_next  = '0;
                state_next = S_RESP;
                priority if (item_reg.command == tccw_pkg::CMD_PUT)
                begin
                    priority if (item_reg.char_code == tccw_pkg::CH_BS)
                    begin
                        if (col_reg != '0)
                        begin
                            col_next   = col_reg - CW'(1);
                            loc_next   = loc_reg - LW'(1);
                            phase_next = phase_dec;
                        end
                    end
                    else if (item_reg.char_code == tccw_pkg::CH_TAB)
                    begin
                        phase_next = '0;
                        if (tab_col >= NCW'(COLUMNS))
                        begin
                            col_next = '0;
                            loc_next = nl_loc;
                            if (last_row)
                            begin
                                state_next = S_SCROLL;
                            end
                        end
                        else
                        begin
                            col_next = CW'(tab_col);
                            loc_next = loc_reg + LW'(tab_delta);
                        end
                    end
                    else if (item_reg.char_code == tccw_pkg::CH_CR)
                    begin
                        col_next   = '0;
                        phase_next = '0;
                        loc_next   = line_base;
                    end
                    else if (item_reg.char_code == tccw_pkg::CH_LF)
                    begin
                        col_next   = '0;
                        phase_next = '0;
                        loc_next   = nl_loc;
                        if (last_row)
                        begin
                            state_next = S_SCROLL;
                        end
                    end
                    else if (item_reg.char_code >= tccw_pkg::CH_SPACE &&
                             item_reg.char_code <= tccw_pkg::CH_DEL)
                    begin
                        we      = 1'b1;
                        wr_addr = loc_reg;
                        wr_data = {item_reg.bg_color, item_reg.fg_color,
                                   item_reg.char_code};
                        if (col_reg == CW'(COLUMNS - 1))
                        begin
                            col_next   = '0;
                            phase_next = '0;
                            loc_next   = nl_loc;
                            if (last_row)
                            begin
                                state_next = S_SCROLL;
                            end
                        end
                        else
                        begin
                            col_next   = col_reg + CW'(1);
                            phase_next = phase_inc;
                            loc_next   = loc_reg + LW'(1);
                        end
                    end
                    else
                    begin
                        loc_next = loc_reg;
                    end
                    cnt_next        = CNTW'(COLUMNS);
                    pend_next       = 1'b0;
                    sweep_resp_next = 1'b1;
                end
                else if (item_reg.command == tccw_pkg::CMD_CLEAR)
                begin
                    col_next        = '0;
                    phase_next      = '0;
                    loc_next        = '0;
                    cnt_next        = '0;
                    sweep_resp_next = 1'b1;
                    state_next      = S_SWEEP;
                end
                else if (item_reg.command == tccw_pkg::CMD_READ)
                begin
                    re         = 1'b1;
                    rd_addr    = LW'(item_reg.cell_address);
                    rd_ok_next = (32'(item_reg.cell_address) < CELLS);
                    state_next = S_RDWAIT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_RDWAIT:
            begin
                data_next  = rd_ok_reg ? rd_data_reg : '0;
                state_next = S_RESP;
            end

            S_SCROLL:
            begin
                if (pend_reg)
                begin
                    we      = 1'b1;
                    wr_addr = dst_reg;
                    wr_data = rd_data_reg;
                end
                if (cnt_reg != CNTW'(CELLS))
                begin
                    re        = 1'b1;
                    rd_addr   = LW'(cnt_reg);
                    dst_next  = LW'(cnt_reg - CNTW'(COLUMNS));
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + CNTW'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    cnt_next   = CNTW'(LAST_BASE);
                    state_next = S_SWEEP;
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.cursor_location = tccw_pkg::LOC_W'(loc_reg);
                    rsp_next.read_data       = data_reg;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            loc_reg        <= '0;
            col_reg        <= '0;
            phase_reg      <= '0;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            sweep_resp_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            loc_reg        <= loc_next;
            col_reg        <= col_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            sweep_resp_reg <= sweep_resp_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        dst_reg   <= dst_next;
        rd_ok_reg <= rd_ok_next;
        data_reg  <= data_next;
        rsp_reg   <= rsp_next;
    end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for text_console_char_writer: put, clear, read, wrap and scroll.
// Response words are checked against an in-bench console model fed with each accepted request word.
// Depends on tccw_pkg and the text_console_char_writer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS      = tccw_pkg::DEF_COLUMNS;
    localparam int ROWS         = tccw_pkg::DEF_ROWS;
    localparam int TAB_WIDTH    = tccw_pkg::DEF_TAB_WIDTH;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int RANDOM_WORDS = 1700;
    localparam int CALM_FROM    = 400;
    localparam int CALM_TO      = 700;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_LEN     = 500;
    localparam int SYNC_AT      = 1000;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 20;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    tccw_pkg::req_word_t req       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    tccw_pkg::rsp_word_t rsp;

    text_console_char_writer #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_WIDTH(TAB_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // console model state
    logic [tccw_pkg::CELL_W-1:0] screen_mem [0:CELLS-1];
    int unsigned                 cur_col;
    int unsigned                 cur_row;

    tccw_pkg::req_word_t pending_q [$];
    tccw_pkg::rsp_word_t rsp_expect_q [$];

    int words_sent;
    int words_seen;
    int fail_count;
    int scroll_count;
    int clear_count;
    int read_count;
    int oob_read_count;
    int put_count;

    function automatic tccw_pkg::rsp_word_t console_step(input tccw_pkg::req_word_t w);
        tccw_pkg::rsp_word_t         r;
        logic [7:0]                  ch;
        logic [tccw_pkg::CELL_W-1:0] data;
        int unsigned                 i;
        ch   = w.char_code;
        data = '0;
        if (w.command == tccw_pkg::CMD_PUT)
        begin
            put_count++;
            if (ch == tccw_pkg::CH_BS)
            begin
                if (cur_col != 0)
                    cur_col--;
            end
            else if (ch == tccw_pkg::CH_TAB)
            begin
                cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
            end
            else if (ch == tccw_pkg::CH_CR)
            begin
                cur_col = 0;
            end
            else if (ch == tccw_pkg::CH_LF)
            begin
                cur_col = 0;
                cur_row++;
            end
            else if (ch >= tccw_pkg::CH_SPACE && ch <= tccw_pkg::CH_DEL)
            begin
                if (cur_row * COLUMNS + cur_col < CELLS)
                    screen_mem[cur_row * COLUMNS + cur_col] =
                        {w.bg_color, w.fg_color, ch};
                cur_col++;
            end
            if (cur_col >= COLUMNS)
            begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= ROWS)
            begin
                scroll_count++;
                for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
                    screen_mem[i] = screen_mem[i + COLUMNS];
                for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                    screen_mem[i] = tccw_pkg::BLANK_CELL;
                cur_row = ROWS - 1;
            end
        end
        else if (w.command == tccw_pkg::CMD_CLEAR)
        begin
            clear_count++;
            for (i = 0; i < CELLS; i++)
                screen_mem[i] = tccw_pkg::BLANK_CELL;
            cur_col = 0;
            cur_row = 0;
        end
        else if (w.command == tccw_pkg::CMD_READ)
        begin
            read_count++;
            if (w.cell_address < CELLS)
                data = screen_mem[w.cell_address];
            else
                oob_read_count++;
        end
        r.cursor_location = tccw_pkg::LOC_W'(cur_row * COLUMNS + cur_col);
        r.read_data       = data;
        return r;
    endfunction

    task automatic queue_word(input logic [1:0] cmd, input logic [7:0] ch,
                              input logic [3:0] bc, input logic [3:0] fc,
                              input logic [tccw_pkg::LOC_W-1:0] addr);
        tccw_pkg::req_word_t w;
        w.command      = cmd;
        w.char_code    = ch;
        w.bg_color     = bc;
        w.fg_color     = fc;
        w.cell_address = addr;
        pending_q.push_back(w);
    endtask

    // driver: hold the word until accepted, idle at random, pause once to drain
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        bit go;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                rsp_expect_q.push_back(console_step(req));
                words_sent++;
            end
            if (!(req_valid && !req_ready))
            begin
                go = pending_q.size() != 0;
                if (words_sent == SYNC_AT && rsp_expect_q.size() != 0)
                    go = 1'b0;
                if (go && !(words_sent >= CALM_FROM && words_sent < CALM_TO)
                    && $urandom_range(0, 99) < 32)
                    go = 1'b0;
                if (go)
                begin
                    req       <= pending_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each response word, stall at random, hold off once
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        tccw_pkg::rsp_word_t exp_w;
        int                  hold_left;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_expect_q.size() == 0)
                begin
                    $error("unexpected response word: cursor_location %0d read_data %h",
                           rsp.cursor_location, rsp.read_data);
                    fail_count++;
                end
                else
                begin
                    exp_w = rsp_expect_q.pop_front();
                    if (rsp.cursor_location !== exp_w.cursor_location)
                    begin
                        $error("cursor_location: expected %0d, got %0d",
                               exp_w.cursor_location, rsp.cursor_location);
                        fail_count++;
                    end
                    if (rsp.read_data !== exp_w.read_data)
                    begin
                        $error("read_data: expected %h, got %h",
                               exp_w.read_data, rsp.read_data);
                        fail_count++;
                    end
                end
                words_seen++;
                if (words_seen == HOLD_AT)
                    hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (words_seen >= CALM_FROM && words_seen < CALM_TO)
            begin
                rsp_ready <= 1'b1;
            end
            else
            begin
                rsp_ready <= $urandom_range(0, 99) >= 32;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin : watchdog_proc
        int quiet;
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $error("no handshake for %0d cycles", quiet);
            $display("FAIL text_console_char_writer");
            $finish;
        end
    end

    initial
    begin : stimulus_proc
        int          i;
        int          k;
        int          pick;
        int          len;
        int          sel;
        logic [3:0]  bc;
        logic [3:0]  fc;
        logic [7:0]  ch;
        logic [10:0] addr;

        for (i = 0; i < CELLS; i++)
            screen_mem[i] = tccw_pkg::BLANK_CELL;
        cur_col = 0;
        cur_row = 0;

        // directed: field extremes, every command, cursor controls, ignored bytes
        queue_word(tccw_pkg::CMD_PUT, 8'h41, 4'h0, 4'h0, 11'd0);
        queue_word(tccw_pkg::CMD_PUT, tccw_pkg::CH_DEL, 4'hF, 4'hF, 11'h7FF);
        queue_word(tccw_pkg::CMD_PUT, tccw_pkg::CH_SPACE, 4'h5, 4'hA, 11'h555);
        queue_word(tccw_pkg::CMD_PUT, tccw_pkg::CH_BS, 4'h0, 4'h0, 11'd0);
        queue_word(tccw_pkg::CMD_PUT, tccw_pkg::CH_CR, 4'hF, 4'hF, 11'h7FF);
        queue_word(tccw_pkg::CMD_PUT, tccw_pkg::CH_BS, 4'h3, 4'hC, 11'h2AA);
        queue_word(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 4'h0, 4'h0, 11'd0);
        queue_word(tccw_pkg::CMD_PUT, 8'h00, 4'hF, 4'hF, 11'd0);
        queue_word(tccw_pkg::CMD_PUT, 8'h1F, 4'h0, 4'h0, 11'h7FF);
        queue_word(tccw_pkg::CMD_PUT, 8'h80, 4'hF, 4'h0, 11'd0);
        queue_word(tccw_pkg::CMD_PUT, 8'hFF, 4'h0, 4'hF, 11'h7FF);
        queue_word(tccw_pkg::CMD_PUT, tccw_pkg::CH_LF, 4'h0, 4'h0, 11'd0);
        queue_word(tccw_pkg::CMD_READ, 8'hFF, 4'hF, 4'hF, 11'd0);
        queue_word(tccw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd1);
        queue_word(tccw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd2);
        queue_word(tccw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd1999);
        queue_word(tccw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd2000);
        queue_word(tccw_pkg::CMD_READ, 8'hFF, 4'hF, 4'hF, 11'h7FF);
        queue_word(tccw_pkg::CMD_NONE, 8'hFF, 4'hF, 4'hF, 11'h7FF);
        queue_word(tccw_pkg::CMD_NONE, 8'h00, 4'h0, 4'h0, 11'd0);
        queue_word(tccw_pkg::CMD_CLEAR, 8'hFF, 4'hF, 4'hF, 11'h7FF);
        queue_word(tccw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd0);

        // random: text runs, cursor play, newline bursts, read probes, noise
        k = pending_q.size();
        while (pending_q.size() < k + RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            bc   = 4'($urandom_range(0, 15));
            fc   = 4'($urandom_range(0, 15));
            if (pick < 40)
            begin
                len = $urandom_range(1, 120);
                for (i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 9) < 3)
                    begin
                        bc = 4'($urandom_range(0, 15));
                        fc = 4'($urandom_range(0, 15));
                    end
                    queue_word(tccw_pkg::CMD_PUT,
                               8'($urandom_range(tccw_pkg::CH_SPACE, tccw_pkg::CH_DEL)),
                               bc, fc, 11'($urandom_range(0, 2047)));
                end
                if ($urandom_range(0, 1) == 0)
                    queue_word(tccw_pkg::CMD_PUT,
                               $urandom_range(0, 1) ? tccw_pkg::CH_LF : tccw_pkg::CH_CR,
                               bc, fc, 11'($urandom_range(0, 2047)));
            end
            else if (pick < 60)
            begin
                len = $urandom_range(1, 10);
                for (i = 0; i < len; i++)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 5)
                        addr = 11'($urandom_range(0, CELLS - 1));
                    else if (sel < 7)
                        addr = 11'($urandom_range((ROWS - 1) * COLUMNS, CELLS - 1));
                    else if (sel < 8)
                        addr = 11'($urandom_range(CELLS, 2047));
                    else
                        addr = 11'($urandom_range(0, 3 * COLUMNS));
                    queue_word(tccw_pkg::CMD_READ, 8'($urandom_range(0, 255)), bc, fc, addr);
                end
            end
            else if (pick < 75)
            begin
                len = $urandom_range(1, 12);
                for (i = 0; i < len; i++)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 2)
                        ch = tccw_pkg::CH_BS;
                    else if (sel < 4)
                        ch = tccw_pkg::CH_TAB;
                    else if (sel < 5)
                        ch = tccw_pkg::CH_CR;
                    else if (sel < 6)
                        ch = tccw_pkg::CH_LF;
                    else if (sel < 7)
                        ch = 8'($urandom_range(0, 8'h1F));
                    else if (sel < 9)
                        ch = 8'($urandom_range(8'h80, 8'hFF));
                    else
                        ch = 8'($urandom_range(tccw_pkg::CH_SPACE, tccw_pkg::CH_DEL));
                    queue_word(tccw_pkg::CMD_PUT, ch, 4'($urandom_range(0, 15)),
                               4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)));
                end
            end
            else if (pick < 83)
            begin
                len = $urandom_range(1, 30);
                for (i = 0; i < len; i++)
                    queue_word(tccw_pkg::CMD_PUT, tccw_pkg::CH_LF, bc, fc,
                               11'($urandom_range(0, 2047)));
            end
            else if (pick < 86)
            begin
                queue_word(tccw_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), bc, fc,
                           11'($urandom_range(0, 2047)));
            end
            else if (pick < 91)
            begin
                queue_word(tccw_pkg::CMD_NONE, 8'($urandom_range(0, 255)), bc, fc,
                           11'($urandom_range(0, 2047)));
            end
            else
            begin
                sel = $urandom_range(0, 99);
                queue_word(sel < 2 ? tccw_pkg::CMD_CLEAR
                                   : 2'($urandom_range(0, 3)) & {1'b1, sel >= 2},
                           8'($urandom_range(0, 255)), bc, fc, 11'($urandom_range(0, 2047)));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || req_valid || rsp_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d request words and %0d response words: %0d puts, %0d reads",
                 words_sent, words_seen, put_count, read_count);
        $display("including %0d out-of-range reads, %0d scrolls and %0d clears",
                 oob_read_count, scroll_count, clear_count);
        if (fail_count == 0)
            $display("PASS text_console_char_writer");
        else
            $display("FAIL text_console_char_writer");
        $finish;
    end

endmodule
